### rtl/kxs_pkg.sv
// shared types, constants and keystream function for the keystream xor block
package kxs_pkg;

  localparam logic [15:0] KS_INIT       = 16'h00a5;
  localparam logic [15:0] KS_ADD        = 16'h9014;
  localparam logic [15:0] LEN_RESET     = 16'd22987;
  localparam logic [15:0] TRAILER_BYTES = 16'd4;
  localparam logic [15:0] POS_MAX       = 16'hffff;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_LEN  = 1'b1;

  // mode codes
  localparam logic MODE_DECRYPT = 1'b0;
  localparam logic MODE_ENCRYPT = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_SUM = 2'd1;
  localparam logic [1:0] STAT_LEN = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_file;
    logic [1:0] status;
  } kxs_result_t;

  // add then rotate left by 3
  function automatic logic [15:0] next_key(input logic [15:0] ks);
    logic [15:0] s;
    s = ks + KS_ADD;
    return {s[12:0], s[15:13]};
  endfunction

endpackage

### rtl/keystream_xor_with_sum_check.sv
// top level: keystream xor stream cipher with 32-bit additive trailer check
//
// usage:
//   in_*   one file byte per beat, in_tlast on the final byte of the file
//   out_*  one result beat per input beat, same order; out_tlast copies the
//          input marker and out_tuser carries the status on that beat
//          (0 ok, 1 sum mismatch, 2 wrong length, 0 on all other beats)
//   cfg_*  register writes (0 mode, 1 expected length), taken at any edge
//          with cfg_we high; write only while the stream is idle
// latency: a result appears one cycle after its input beat is accepted
// throughput: one byte per cycle; the keystream add-rotate, the sum add and
//   the trailer compare all settle between the stream state and the output
//   register in one cycle
// stall: the single output register holds its beat while out_tready is low;
//   in_tready follows it, so a new beat is taken in the same cycle the held
//   one leaves
// reset: rst_n low clears the stream state (keystream 0x00a5, position,
//   sum, trailer), empties the output register and restores mode 0 and
//   expected length 22987; stream state also restarts after every last byte
module keystream_xor_with_sum_check (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // end_of_file
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import kxs_pkg::*;

  logic        mode_r;
  logic [15:0] exp_len_r;
  logic        out_valid_r;
  kxs_result_t out_r;
  kxs_result_t core_res;
  logic        accept;

  // output register drains or is empty: room for a new beat
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DECRYPT;
      exp_len_r <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MODE: mode_r    <= cfg_wdata[0];
        CFG_LEN:  exp_len_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  kxs_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_tdata),
    .last_byte       (in_tlast),
    .mode            (mode_r),
    .expected_length (exp_len_r),
    .result          (core_res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // output payload, loaded on every accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.out_byte;
  assign out_tlast  = out_r.end_of_file;
  assign out_tuser  = out_r.status;

endmodule

### rtl/kxs_core.sv
// per-file stream state and combinational byte transform
module kxs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                mode,
  input  logic [15:0]         expected_length,
  output kxs_pkg::kxs_result_t result
);
  import kxs_pkg::*;

  logic [15:0] keystream_r, keystream_nxt;
  logic [15:0] byte_pos_r, byte_pos_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] trailer_r, trailer_nxt;

  logic        has_trailer;
  logic [15:0] start;
  logic        in_body, in_trailer;
  logic [1:0]  lane;
  logic [7:0]  key, sum_lane, plain, res_byte;
  logic        len_ok;
  logic [1:0]  status;
  logic [16:0] len_now;

  always_comb begin
    has_trailer   = expected_length >= TRAILER_BYTES;
    start         = has_trailer ? (expected_length - TRAILER_BYTES) : '0;
    in_body       = has_trailer && (byte_pos_r < start);
    in_trailer    = has_trailer && (byte_pos_r >= start) && (byte_pos_r < expected_length);
    lane          = byte_pos_r[1:0] - start[1:0];
    keystream_nxt = next_key(keystream_r);
    key           = keystream_nxt[7:0];
    case (lane)
      2'd0:    sum_lane = sum_r[7:0];
      2'd1:    sum_lane = sum_r[15:8];
      2'd2:    sum_lane = sum_r[23:16];
      default: sum_lane = sum_r[31:24];
    endcase
    if (mode == MODE_DECRYPT) begin
      plain    = data_byte ^ key;
      res_byte = plain;
    end else begin
      plain    = in_trailer ? sum_lane : data_byte;
      res_byte = plain ^ key;
    end
    sum_nxt     = sum_r;
    trailer_nxt = trailer_r;
    if (in_body) begin
      sum_nxt = sum_r + {24'd0, plain};
    end else if (in_trailer) begin
      case (lane)
        2'd0:    trailer_nxt[7:0]   = plain;
        2'd1:    trailer_nxt[15:8]  = plain;
        2'd2:    trailer_nxt[23:16] = plain;
        default: trailer_nxt[31:24] = plain;
      endcase
    end
    byte_pos_nxt = (byte_pos_r != POS_MAX) ? (byte_pos_r + 16'd1) : byte_pos_r;
    // length of the file if this byte ends it
    len_now = {1'b0, byte_pos_r} + 17'd1;
    len_ok  = has_trailer && (byte_pos_r != POS_MAX) && (len_now == {1'b0, expected_length});
    if (!last_byte)                status = STAT_OK;
    else if (!len_ok)              status = STAT_LEN;
    else if (sum_nxt != trailer_nxt) status = STAT_SUM;
    else                           status = STAT_OK;
    result.out_byte    = res_byte;
    result.end_of_file = last_byte;
    result.status      = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keystream_r <= KS_INIT;
      byte_pos_r  <= '0;
      sum_r       <= '0;
      trailer_r   <= '0;
    end else if (accept) begin
      if (last_byte) begin
        keystream_r <= KS_INIT;
        byte_pos_r  <= '0;
        sum_r       <= '0;
        trailer_r   <= '0;
      end else begin
        keystream_r <= keystream_nxt;
        byte_pos_r  <= byte_pos_nxt;
        sum_r       <= sum_nxt;
        trailer_r   <= trailer_nxt;
      end
    end
  end

endmodule
